FILE: hdl/bbcm_pkg.sv
// ----------------------------------------------------------------------------
// bbcm_pkg: shared types and constants of the buffer cache manager
// Request and response payloads, operation and status codes, flag bits,
// the controller to datapath command and status, and a flag helper.
// ----------------------------------------------------------------------------
package bbcm_pkg;

    localparam int NUM_BUFFERS_DEF  = 16;
    localparam int DEVICE_WIDTH_DEF = 16;
    localparam int BLOCK_WIDTH_DEF  = 32;

    localparam int FLAG_WIDTH = 7;

    localparam int FL_BUSY   = 0;
    localparam int FL_WANTED = 1;
    localparam int FL_DONE   = 2;
    localparam int FL_DELWRI = 3;
    localparam int FL_ASYNC  = 4;
    localparam int FL_AGE    = 5;
    localparam int FL_ERROR  = 6;

    typedef enum logic [2:0] {
        FUNC_GET       = 3'd0,
        FUNC_RELEASE   = 3'd1,
        FUNC_DW_RELEASE = 3'd2,
        FUNC_IO_DONE   = 3'd3,
        FUNC_WRITE     = 3'd4,
        FUNC_FLUSH     = 3'd5
    } func_t;

    typedef enum logic [2:0] {
        ST_HIT   = 3'd0,
        ST_MISS  = 3'd1,
        ST_BUSY  = 3'd2,
        ST_EMPTY = 3'd3,
        ST_WB    = 3'd4,
        ST_DONE  = 3'd5,
        ST_NONE  = 3'd6
    } status_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] device;
        logic [31:0] block_number;
        logic [3:0]  buffer_index;
        logic        flush_all_devices;
        logic        io_error;
        logic        write_async;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  result_index;
        logic [15:0] evicted_device;
        logic [31:0] evicted_block;
        logic        data_valid;
        logic        wake_buffer_waiters;
        logic        wake_pool_waiters;
    } rsp_t;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_LATCH,
        CMD_SEARCH,
        CMD_EXEC,
        CMD_WALK
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic is_flush;
        logic walk_done;
    } dp_status_t;

    function automatic logic [FLAG_WIDTH-1:0] start_write_flags(
        input logic [FLAG_WIDTH-1:0] old,
        input logic                  async
    );
        logic [FLAG_WIDTH-1:0] f;
        f = old;
        f[FL_DONE]   = 1'b0;
        f[FL_ERROR]  = 1'b0;
        f[FL_DELWRI] = 1'b0;
        f[FL_AGE]    = async & old[FL_DELWRI];
        f[FL_ASYNC]  = async;
        return f;
    endfunction

endpackage

FILE: hdl/bbcm_ctrl.sv
// ----------------------------------------------------------------------------
// bbcm_ctrl: request sequencer of the buffer cache manager
// Steps each request through latch, tag search, execution or free list
// walk, and response hold, issuing one command to the datapath per cycle.
// ----------------------------------------------------------------------------
module bbcm_ctrl
    import bbcm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output dp_cmd_t    cmd,
    input  dp_status_t dp_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_EXEC,
        S_WALK,
        S_RESP
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = CMD_NOP;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.op     = CMD_LATCH;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                cmd.op     = CMD_SEARCH;
                state_next = dp_status.is_flush ? S_WALK : S_EXEC;
            end
            S_EXEC:
            begin
                cmd.op     = CMD_EXEC;
                state_next = S_RESP;
            end
            S_WALK:
            begin
                cmd.op = CMD_WALK;
                if (dp_status.walk_done)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_RESP);

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_ready && rsp_valid))
        else $error("Request and response sides are open at once.");

    a_accept_to_search: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == S_SEARCH))
        else $error("An accepted request did not enter the tag search.");

    a_resp_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> ($past(state_reg) == S_EXEC || $past(state_reg) == S_WALK))
        else $error("A response appeared without an execution step.");

endmodule

FILE: hdl/bbcm_datapath.sv
// ----------------------------------------------------------------------------
// bbcm_datapath: tags, flags and LRU free list of the buffer pool
// Holds the request, searches all tags, walks the free list one node per
// cycle for flushes, and applies one buffer update and list relink per op.
// ----------------------------------------------------------------------------
module bbcm_datapath
    import bbcm_pkg::*;
#(
    parameter int NUM_BUFFERS  = NUM_BUFFERS_DEF,
    parameter int DEVICE_WIDTH = DEVICE_WIDTH_DEF,
    parameter int BLOCK_WIDTH  = BLOCK_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  req_t       req,
    input  dp_cmd_t    cmd,
    output dp_status_t dp_status,
    output rsp_t       rsp
);

    localparam int IW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
    localparam int CW = $clog2(NUM_BUFFERS + 1);

    typedef logic [IW-1:0]         idx_t;
    typedef logic [FLAG_WIDTH-1:0] flags_t;

    req_t                    req_reg;
    logic                    hit_found_reg;
    idx_t                    hit_idx_reg;
    idx_t                    walk_cur_reg, walk_cur_next;
    logic [CW-1:0]           walk_k_reg, walk_k_next;
    rsp_t                    rsp_reg, rsp_next;

    logic [NUM_BUFFERS-1:0]  tv_reg, tv_next;
    logic [DEVICE_WIDTH-1:0] tdev_reg [NUM_BUFFERS];
    logic [DEVICE_WIDTH-1:0] tdev_next [NUM_BUFFERS];
    logic [BLOCK_WIDTH-1:0]  tblk_reg [NUM_BUFFERS];
    logic [BLOCK_WIDTH-1:0]  tblk_next [NUM_BUFFERS];
    flags_t                  flg_reg [NUM_BUFFERS];
    flags_t                  flg_next [NUM_BUFFERS];
    idx_t                    nxt_reg [NUM_BUFFERS];
    idx_t                    nxt_next [NUM_BUFFERS];
    idx_t                    prv_reg [NUM_BUFFERS];
    idx_t                    prv_next [NUM_BUFFERS];
    logic [NUM_BUFFERS-1:0]  onf_reg, onf_next;
    idx_t                    head_reg, head_next;
    idx_t                    tail_reg, tail_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic                    poolw_reg, poolw_next;

    logic [DEVICE_WIDTH-1:0] dev_q;
    logic [BLOCK_WIDTH-1:0]  blk_q;
    logic                    search_found;
    idx_t                    search_idx;
    logic                    walk_end;
    logic                    walk_match;

    assign dev_q = DEVICE_WIDTH'(req_reg.device);
    assign blk_q = BLOCK_WIDTH'(req_reg.block_number);

    always_comb
    begin
        search_found = 1'b0;
        search_idx   = '0;
        for (int n = NUM_BUFFERS - 1; n >= 0; n--)
        begin
            if (tv_reg[n] && tdev_reg[n] == dev_q && tblk_reg[n] == blk_q)
            begin
                search_found = 1'b1;
                search_idx   = IW'(n);
            end
        end
    end

    assign walk_end   = (walk_k_reg >= cnt_reg);
    assign walk_match = !walk_end && flg_reg[walk_cur_reg][FL_DELWRI] &&
                        (req_reg.flush_all_devices ||
                         (tv_reg[walk_cur_reg] && tdev_reg[walk_cur_reg] == dev_q));

    assign dp_status.is_flush  = (req_reg.func == FUNC_FLUSH);
    assign dp_status.walk_done = walk_end || walk_match;

    always_comb
    begin
        idx_t   i;
        idx_t   p;
        idx_t   n;
        logic   act;
        logic   unl;
        logic   ins;
        logic   at_head;
        logic   fl_we;
        flags_t fl_new;
        flags_t f;
        logic   tv_we;
        logic   tv_val;
        logic   tag_we;
        logic   evict;
        logic   idx_ok;

        tv_next       = tv_reg;
        tdev_next     = tdev_reg;
        tblk_next     = tblk_reg;
        flg_next      = flg_reg;
        nxt_next      = nxt_reg;
        prv_next      = prv_reg;
        onf_next      = onf_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        cnt_next      = cnt_reg;
        poolw_next    = poolw_reg;
        walk_cur_next = walk_cur_reg;
        walk_k_next   = walk_k_reg;
        rsp_next      = rsp_reg;

        i       = IW'(req_reg.buffer_index);
        p       = '0;
        n       = '0;
        act     = 1'b0;
        unl     = 1'b0;
        ins     = 1'b0;
        at_head = 1'b0;
        fl_we   = 1'b0;
        fl_new  = '0;
        f       = '0;
        tv_we   = 1'b0;
        tv_val  = 1'b0;
        tag_we  = 1'b0;
        evict   = 1'b0;
        idx_ok  = (9'(req_reg.buffer_index) < 9'(NUM_BUFFERS));

        if (cmd.op == CMD_SEARCH)
        begin
            walk_cur_next = head_reg;
            walk_k_next   = '0;
        end

        if (cmd.op == CMD_EXEC || cmd.op == CMD_WALK)
        begin
            act      = 1'b1;
            rsp_next = '0;
            rsp_next.status = ST_NONE;
        end

        if (cmd.op == CMD_WALK)
        begin
            if (walk_match)
            begin
                i      = walk_cur_reg;
                unl    = 1'b1;
                fl_we  = 1'b1;
                f      = flg_reg[i];
                f[FL_BUSY] = 1'b1;
                fl_new = start_write_flags(f, 1'b1);
                evict  = 1'b1;
                rsp_next.status       = ST_WB;
                rsp_next.result_index = 4'(i);
            end
            else if (!walk_end)
            begin
                walk_cur_next = nxt_reg[walk_cur_reg];
                walk_k_next   = walk_k_reg + 1'b1;
            end
        end
        else if (cmd.op == CMD_EXEC)
        begin
            if (req_reg.func == FUNC_GET)
            begin
                if (hit_found_reg)
                begin
                    i = hit_idx_reg;
                    rsp_next.result_index = 4'(i);
                    fl_we = 1'b1;
                    f     = flg_reg[i];
                    if (f[FL_BUSY])
                    begin
                        f[FL_WANTED] = 1'b1;
                        fl_new = f;
                        rsp_next.status = ST_BUSY;
                    end
                    else
                    begin
                        unl = 1'b1;
                        f[FL_BUSY] = 1'b1;
                        fl_new = f;
                        rsp_next.data_valid = f[FL_DONE];
                        rsp_next.status = ST_HIT;
                    end
                end
                else if (cnt_reg == '0)
                begin
                    poolw_next = 1'b1;
                    rsp_next.status = ST_EMPTY;
                end
                else
                begin
                    i     = head_reg;
                    unl   = 1'b1;
                    fl_we = 1'b1;
                    rsp_next.result_index = 4'(i);
                    f = flg_reg[i];
                    f[FL_BUSY] = 1'b1;
                    if (f[FL_DELWRI])
                    begin
                        fl_new = start_write_flags(f, 1'b1);
                        evict  = 1'b1;
                        rsp_next.status = ST_WB;
                    end
                    else
                    begin
                        fl_new = '0;
                        fl_new[FL_BUSY] = 1'b1;
                        tv_we  = 1'b1;
                        tv_val = 1'b1;
                        tag_we = 1'b1;
                        rsp_next.status = ST_MISS;
                    end
                end
            end
            else if (idx_ok && (req_reg.func == FUNC_RELEASE ||
                                req_reg.func == FUNC_DW_RELEASE ||
                                req_reg.func == FUNC_IO_DONE ||
                                req_reg.func == FUNC_WRITE))
            begin
                rsp_next.status       = ST_DONE;
                rsp_next.result_index = req_reg.buffer_index;
                fl_we = 1'b1;
                f     = flg_reg[i];
                if (req_reg.func == FUNC_WRITE)
                begin
                    unl = 1'b1;
                    f[FL_BUSY] = 1'b1;
                    fl_new = start_write_flags(f, req_reg.write_async);
                    evict  = 1'b1;
                end
                else
                begin
                    if (req_reg.func == FUNC_DW_RELEASE)
                    begin
                        f[FL_DELWRI] = 1'b1;
                        f[FL_DONE]   = 1'b1;
                    end
                    if (req_reg.func == FUNC_IO_DONE)
                    begin
                        f[FL_DONE] = 1'b1;
                        if (req_reg.io_error)
                        begin
                            f[FL_ERROR] = 1'b1;
                        end
                    end
                    if (req_reg.func == FUNC_IO_DONE && !f[FL_ASYNC])
                    begin
                        f[FL_WANTED] = 1'b0;
                        fl_new = f;
                        rsp_next.wake_buffer_waiters = 1'b1;
                    end
                    else
                    begin
                        rsp_next.wake_buffer_waiters = f[FL_WANTED];
                        if (poolw_reg)
                        begin
                            rsp_next.wake_pool_waiters = 1'b1;
                            poolw_next = 1'b0;
                        end
                        if (f[FL_ERROR])
                        begin
                            tv_we  = 1'b1;
                            tv_val = 1'b0;
                        end
                        unl     = 1'b1;
                        ins     = 1'b1;
                        at_head = f[FL_AGE];
                        fl_new  = f;
                        fl_new[FL_WANTED] = 1'b0;
                        fl_new[FL_BUSY]   = 1'b0;
                        fl_new[FL_ASYNC]  = 1'b0;
                        fl_new[FL_AGE]    = 1'b0;
                    end
                end
            end
        end

        if (act && evict)
        begin
            rsp_next.evicted_device = 16'(tdev_reg[i]);
            rsp_next.evicted_block  = 32'(tblk_reg[i]);
        end

        if (unl && onf_next[i])
        begin
            p = prv_next[i];
            n = nxt_next[i];
            if (head_next == i)
            begin
                head_next = n;
            end
            else
            begin
                nxt_next[p] = n;
            end
            if (tail_next == i)
            begin
                tail_next = p;
            end
            else
            begin
                prv_next[n] = p;
            end
            onf_next[i] = 1'b0;
            if (cnt_next != '0)
            begin
                cnt_next = cnt_next - 1'b1;
            end
        end

        if (ins)
        begin
            if (cnt_next == '0)
            begin
                head_next   = i;
                tail_next   = i;
                nxt_next[i] = i;
                prv_next[i] = i;
            end
            else if (at_head)
            begin
                nxt_next[i]         = head_next;
                prv_next[head_next] = i;
                head_next           = i;
            end
            else
            begin
                prv_next[i]         = tail_next;
                nxt_next[tail_next] = i;
                tail_next           = i;
            end
            onf_next[i] = 1'b1;
            cnt_next    = cnt_next + 1'b1;
        end

        if (fl_we)
        begin
            flg_next[i] = fl_new;
        end
        if (tv_we)
        begin
            tv_next[i] = tv_val;
        end
        if (tag_we)
        begin
            tdev_next[i] = dev_q;
            tblk_next[i] = blk_q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == CMD_LATCH)
        begin
            req_reg <= req;
        end
        if (cmd.op == CMD_SEARCH)
        begin
            hit_found_reg <= search_found;
            hit_idx_reg   <= search_idx;
        end
        walk_cur_reg <= walk_cur_next;
        walk_k_reg   <= walk_k_next;
        rsp_reg      <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tv_reg    <= '0;
            onf_reg   <= '1;
            head_reg  <= '0;
            tail_reg  <= IW'(NUM_BUFFERS - 1);
            cnt_reg   <= CW'(NUM_BUFFERS);
            poolw_reg <= 1'b0;
            for (int k = 0; k < NUM_BUFFERS; k++)
            begin
                tdev_reg[k] <= '0;
                tblk_reg[k] <= '0;
                flg_reg[k]  <= '0;
                nxt_reg[k]  <= IW'((k + 1) % NUM_BUFFERS);
                prv_reg[k]  <= IW'((k + NUM_BUFFERS - 1) % NUM_BUFFERS);
            end
        end
        else
        begin
            tv_reg    <= tv_next;
            onf_reg   <= onf_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            cnt_reg   <= cnt_next;
            poolw_reg <= poolw_next;
            tdev_reg  <= tdev_next;
            tblk_reg  <= tblk_next;
            flg_reg   <= flg_next;
            nxt_reg   <= nxt_next;
            prv_reg   <= prv_next;
        end
    end

    assign rsp = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(NUM_BUFFERS))
        else $error("Free count exceeds the pool size.");

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(onf_reg) == int'(cnt_reg))
        else $error("Free count disagrees with the free list membership.");

    a_head_on_list: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) |-> (onf_reg[head_reg] && onf_reg[tail_reg]))
        else $error("Free list head or tail is not on the free list.");

endmodule

FILE: hdl/block_buffer_cache_manager_top.sv
// ----------------------------------------------------------------------------
// block_buffer_cache_manager_top: buffer cache tag and replacement manager
// Tag lookup, claim, write-back start and LRU free list relink per request.
// ----------------------------------------------------------------------------
// Sequencing: a non-flush request passes the search and execute steps before
// its response is valid; a flush walks the free list node by node instead.
// One request in flight: the sequencer passes the idle, search, execute or
// walk, and response steps before it accepts the next request.
// Reset: rst_n clears all tags and flags and chains every buffer on the
// free list in index order; req_ready is high as soon as reset is applied.
// ----------------------------------------------------------------------------
module block_buffer_cache_manager_top
    import bbcm_pkg::*;
#(
    parameter int NUM_BUFFERS  = NUM_BUFFERS_DEF,
    parameter int DEVICE_WIDTH = DEVICE_WIDTH_DEF,
    parameter int BLOCK_WIDTH  = BLOCK_WIDTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    dp_cmd_t    cmd;
    dp_status_t dp_status;

    bbcm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .dp_status (dp_status)
    );

    bbcm_datapath #(
        .NUM_BUFFERS  (NUM_BUFFERS),
        .DEVICE_WIDTH (DEVICE_WIDTH),
        .BLOCK_WIDTH  (BLOCK_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .dp_status (dp_status),
        .rsp       (rsp)
    );

endmodule
